@@ hdl/b2d_pkg.sv @@
package b2d_pkg;

    localparam int VALUE_W       = 32;
    localparam int DEC_W         = 2;
    localparam int COORD_W       = 8;
    localparam int TEXT_X_W      = 9;
    localparam int CHAR_W        = 7;
    localparam int FONT_W        = 5;
    localparam int DIGIT_W       = 4;
    localparam int OFFSET_W      = 7;
    localparam int BITS_PER_STEP = 4;
    localparam int DABBLE_CYCLES = VALUE_W / BITS_PER_STEP;
    localparam int CNT_W         = $clog2(DABBLE_CYCLES);

    localparam logic [FONT_W-1:0] FONT_W_RESET = 5'd8;

    localparam logic [DEC_W-1:0] DEC_NONE  = 2'd0;
    localparam logic [DEC_W-1:0] DEC_ONE   = 2'd1;
    localparam logic [DEC_W-1:0] DEC_TWO   = 2'd2;
    localparam logic [DEC_W-1:0] DEC_UNITS = 2'd3;

    localparam logic [VALUE_W-1:0] LIMIT_10   = 32'd10;
    localparam logic [VALUE_W-1:0] LIMIT_100  = 32'd100;
    localparam logic [VALUE_W-1:0] LIMIT_1000 = 32'd1000;

    localparam logic [DIGIT_W-1:0] DABBLE_LIMIT = 4'd4;
    localparam logic [DIGIT_W-1:0] DABBLE_ADD   = 4'd3;

    typedef logic [DIGIT_W-1:0] t_digit;
    typedef logic [CHAR_W-1:0]  t_char;

    localparam t_char ASCII_ZERO  = 7'h30;
    localparam t_char ASCII_POINT = 7'h2E;

    typedef struct packed {
        logic                valid;
        logic [TEXT_X_W-1:0] text_x;
        logic [COORD_W-1:0]  text_y;
        logic [DEC_W-1:0]    decimals;
    } t_conv_out;

endpackage

@@ hdl/b2d_dabble_cell.sv @@
module b2d_dabble_cell (
    input  logic                                i_clk,
    input  logic                                i_clear,
    input  logic                                i_step,
    input  logic [b2d_pkg::BITS_PER_STEP-1:0]   i_shift_in,
    output b2d_pkg::t_digit                     o_digit,
    output logic [b2d_pkg::BITS_PER_STEP-1:0]   o_shift_out
);
    import b2d_pkg::*;

    t_digit r_digit;
    t_digit n_digit;
    t_digit w_d;

    // Each step handles four bits in turn: add three to a digit above four, then shift one bit in from below.
    always_comb begin
        w_d = r_digit;
        for (int s = BITS_PER_STEP - 1; s >= 0; s--) begin
            if (w_d > DABBLE_LIMIT) begin
                w_d = w_d + DABBLE_ADD;
            end
            o_shift_out[s] = w_d[DIGIT_W-1];
            w_d = {w_d[DIGIT_W-2:0], i_shift_in[s]};
        end
        n_digit = w_d;
    end

    always_ff @(posedge i_clk) begin
        if (i_clear) begin
            r_digit <= '0;
        end else if (i_step) begin
            r_digit <= n_digit;
        end
    end

    assign o_digit = r_digit;

endmodule

@@ hdl/b2d_converter.sv @@
module b2d_converter #(
    parameter int BCD_DIGITS = 8
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_start,
    input  logic [b2d_pkg::VALUE_W-1:0]          i_value,
    input  logic [b2d_pkg::DEC_W-1:0]            i_decimals,
    input  logic [b2d_pkg::COORD_W-1:0]          i_origin_x,
    input  logic [b2d_pkg::COORD_W-1:0]          i_origin_y,
    input  logic [b2d_pkg::FONT_W-1:0]           i_font_width,
    input  logic                                 i_out_ready,
    output logic                                 o_busy,
    output b2d_pkg::t_conv_out                   o_conv,
    output logic [BCD_DIGITS*b2d_pkg::DIGIT_W-1:0] o_digits
);
    import b2d_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_RUN  = 3'b010,
        S_DONE = 3'b100
    } t_state;

    t_state               r_state;
    t_state               n_state;
    logic [CNT_W-1:0]     r_cnt;
    logic [VALUE_W-1:0]   r_bits;
    logic [TEXT_X_W-1:0]  r_text_x;
    logic [COORD_W-1:0]   r_text_y;
    logic [DEC_W-1:0]     r_decimals;

    logic                 w_accept;
    logic                 w_step;
    logic                 w_lt10;
    logic                 w_lt100;
    logic                 w_lt1000;
    logic [1:0]           w_mul;
    logic                 w_half;
    logic [OFFSET_W-1:0]  w_off;
    logic [TEXT_X_W-1:0]  w_text_x;

    logic [BITS_PER_STEP-1:0] w_link [BCD_DIGITS];

    assign o_busy   = !((r_state == S_IDLE) || ((r_state == S_DONE) && i_out_ready));
    assign w_accept = i_start && !o_busy;
    assign w_step   = (r_state == S_RUN);

    assign w_lt10   = (i_value < LIMIT_10);
    assign w_lt100  = (i_value < LIMIT_100);
    assign w_lt1000 = (i_value < LIMIT_1000);

    always_comb begin
        w_mul  = 2'd0;
        w_half = 1'b0;
        case (i_decimals)
            DEC_NONE: begin
                w_half = w_lt1000;
                if (w_lt10) begin
                    w_mul = 2'd3;
                end else if (w_lt100) begin
                    w_mul = 2'd2;
                end else if (w_lt1000) begin
                    w_mul = 2'd1;
                end
            end
            DEC_ONE: begin
                if (w_lt100) begin
                    w_mul = 2'd2;
                end else if (w_lt1000) begin
                    w_mul = 2'd1;
                end
            end
            DEC_TWO: begin
                if (w_lt1000) begin
                    w_mul = 2'd1;
                end
            end
            default: begin
                w_mul  = 2'd0;
                w_half = 1'b0;
            end
        endcase
        w_off = (w_mul[1] ? (OFFSET_W'(i_font_width) << 1) : '0)
              + (w_mul[0] ? OFFSET_W'(i_font_width) : '0)
              + (w_half ? OFFSET_W'(i_font_width >> 1) : '0);
        w_text_x = TEXT_X_W'(i_origin_x) + TEXT_X_W'(w_off);
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_state = S_RUN;
                end
            end
            S_RUN: begin
                if (r_cnt == CNT_W'(DABBLE_CYCLES - 1)) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (i_out_ready) begin
                    n_state = w_accept ? S_RUN : S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_cnt      <= '0;
            r_bits     <= i_value;
            r_text_x   <= w_text_x;
            r_text_y   <= i_origin_y;
            r_decimals <= i_decimals;
        end else if (w_step) begin
            r_cnt  <= r_cnt + 1'b1;
            r_bits <= r_bits << BITS_PER_STEP;
        end
    end

    assign w_link[0] = r_bits[VALUE_W-1 -: BITS_PER_STEP];

    for (genvar g = 0; g < BCD_DIGITS; g++) begin : g_cell
        if (g == BCD_DIGITS - 1) begin : g_top
            b2d_dabble_cell u_cell (
                .i_clk       (i_clk),
                .i_clear     (w_accept),
                .i_step      (w_step),
                .i_shift_in  (w_link[g]),
                .o_digit     (o_digits[g*DIGIT_W +: DIGIT_W]),
                .o_shift_out ()
            );
        end else begin : g_mid
            b2d_dabble_cell u_cell (
                .i_clk       (i_clk),
                .i_clear     (w_accept),
                .i_step      (w_step),
                .i_shift_in  (w_link[g]),
                .o_digit     (o_digits[g*DIGIT_W +: DIGIT_W]),
                .o_shift_out (w_link[g+1])
            );
        end
    end

    assign o_conv.valid    = (r_state == S_DONE);
    assign o_conv.text_x   = r_text_x;
    assign o_conv.text_y   = r_text_y;
    assign o_conv.decimals = r_decimals;

endmodule

@@ hdl/b2d_emitter.sv @@
module b2d_emitter #(
    parameter int BCD_DIGITS = 8
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  b2d_pkg::t_conv_out                     i_conv,
    input  logic [BCD_DIGITS*b2d_pkg::DIGIT_W-1:0] i_digits,
    output logic                                   o_ready,
    output logic                                   o_strobe,
    output b2d_pkg::t_char                         o_char_code,
    output logic [b2d_pkg::TEXT_X_W-1:0]           o_text_x,
    output logic [b2d_pkg::COORD_W-1:0]            o_text_y,
    output logic                                   o_last_char
);
    import b2d_pkg::*;

    localparam int MAX_CHARS = ((BCD_DIGITS > 3) ? BCD_DIGITS : 3) + 1;
    localparam int IDX_W     = $clog2(MAX_CHARS);
    localparam int LEN_W     = $clog2(MAX_CHARS + 1);

    t_char                r_chars [MAX_CHARS];
    logic [IDX_W-1:0]     r_idx;
    logic                 r_active;
    logic [TEXT_X_W-1:0]  r_text_x;
    logic [COORD_W-1:0]   r_text_y;

    t_digit               w_dig    [MAX_CHARS];
    t_digit               w_dig_up [MAX_CHARS];
    t_char                w_chars  [MAX_CHARS];
    logic [LEN_W-1:0]     w_top;
    logic [LEN_W-1:0]     w_min;
    logic [LEN_W-1:0]     w_len;
    logic [LEN_W-1:0]     w_n;
    logic                 w_take;

    for (genvar g = 0; g < MAX_CHARS; g++) begin : g_dig
        if (g < BCD_DIGITS) begin : g_real
            assign w_dig[g] = i_digits[g*DIGIT_W +: DIGIT_W];
        end else begin : g_pad
            assign w_dig[g] = '0;
        end
        if (g == 0) begin : g_first
            assign w_dig_up[g] = '0;
        end else begin : g_rest
            assign w_dig_up[g] = w_dig[g-1];
        end
    end

    // Characters are laid out from the lowest digit upward; slot zero goes out last.
    always_comb begin
        w_top = '0;
        for (int k = 0; k < BCD_DIGITS; k++) begin
            if (w_dig[k] != '0) begin
                w_top = LEN_W'(k + 1);
            end
        end
        w_min = LEN_W'(i_conv.decimals) + 1'b1;
        if (i_conv.decimals == DEC_UNITS) begin
            w_len = LEN_W'(1);
        end else begin
            w_len = (w_top > w_min) ? w_top : w_min;
        end
        w_n = w_len + LEN_W'((i_conv.decimals == DEC_ONE) || (i_conv.decimals == DEC_TWO));

        for (int j = 0; j < MAX_CHARS; j++) begin
            case (i_conv.decimals)
                DEC_ONE: begin
                    if (j == 1) begin
                        w_chars[j] = ASCII_POINT;
                    end else if (j == 0) begin
                        w_chars[j] = ASCII_ZERO + CHAR_W'(w_dig[j]);
                    end else begin
                        w_chars[j] = ASCII_ZERO + CHAR_W'(w_dig_up[j]);
                    end
                end
                DEC_TWO: begin
                    if (j == 2) begin
                        w_chars[j] = ASCII_POINT;
                    end else if (j < 2) begin
                        w_chars[j] = ASCII_ZERO + CHAR_W'(w_dig[j]);
                    end else begin
                        w_chars[j] = ASCII_ZERO + CHAR_W'(w_dig_up[j]);
                    end
                end
                default: begin
                    w_chars[j] = ASCII_ZERO + CHAR_W'(w_dig[j]);
                end
            endcase
        end
    end

    assign o_ready = !r_active || (r_idx == '0);
    assign w_take  = i_conv.valid && o_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= 1'b0;
        end else if (w_take) begin
            r_active <= 1'b1;
        end else if (r_active && (r_idx == '0)) begin
            r_active <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_idx    <= IDX_W'(w_n - 1'b1);
            r_chars  <= w_chars;
            r_text_x <= i_conv.text_x;
            r_text_y <= i_conv.text_y;
        end else if (r_active && (r_idx != '0)) begin
            r_idx <= r_idx - 1'b1;
        end
    end

    assign o_strobe    = r_active;
    assign o_char_code = r_chars[r_idx];
    assign o_text_x    = r_text_x;
    assign o_text_y    = r_text_y;
    assign o_last_char = (r_idx == '0);

endmodule

@@ hdl/binary_to_decimal_text_formatter.sv @@
// Channel    Direction  Handshake             Word
// input      in         start high, busy low  i_value, i_decimals, i_origin_x, i_origin_y
// result     out        o_strobe, one cycle   o_char_code, o_text_x, o_text_y, o_last_char
// config     in         i_cfg_we              i_cfg_wdata (font width)
//
// A number is converted by the row of BCD digit cells, four value bits a cycle, and then
// sent out one character a cycle, one to nine characters per number.
// Conversion of the next number overlaps the character output of the previous one; a new
// number is taken once the previous one is converted and handed over to the output.
// Reset is synchronous and active low; the font width returns to eight.
// The receiver cannot stall: each character is on the ports for exactly one cycle.
module binary_to_decimal_text_formatter #(
    parameter int BCD_DIGITS = 8
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [b2d_pkg::VALUE_W-1:0]   i_value,
    input  logic [b2d_pkg::DEC_W-1:0]     i_decimals,
    input  logic [b2d_pkg::COORD_W-1:0]   i_origin_x,
    input  logic [b2d_pkg::COORD_W-1:0]   i_origin_y,
    input  logic                          i_cfg_we,
    input  logic [b2d_pkg::FONT_W-1:0]    i_cfg_wdata,
    output logic                          o_strobe,
    output b2d_pkg::t_char                o_char_code,
    output logic [b2d_pkg::TEXT_X_W-1:0]  o_text_x,
    output logic [b2d_pkg::COORD_W-1:0]   o_text_y,
    output logic                          o_last_char
);
    import b2d_pkg::*;

    logic [FONT_W-1:0]               r_font_width;
    t_conv_out                       w_conv;
    logic [BCD_DIGITS*DIGIT_W-1:0]   w_digits;
    logic                            w_emit_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_font_width <= FONT_W_RESET;
        end else if (i_cfg_we) begin
            r_font_width <= i_cfg_wdata;
        end
    end

    b2d_converter #(
        .BCD_DIGITS (BCD_DIGITS)
    ) u_converter (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start      (start),
        .i_value      (i_value),
        .i_decimals   (i_decimals),
        .i_origin_x   (i_origin_x),
        .i_origin_y   (i_origin_y),
        .i_font_width (r_font_width),
        .i_out_ready  (w_emit_ready),
        .o_busy       (busy),
        .o_conv       (w_conv),
        .o_digits     (w_digits)
    );

    b2d_emitter #(
        .BCD_DIGITS (BCD_DIGITS)
    ) u_emitter (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_conv      (w_conv),
        .i_digits    (w_digits),
        .o_ready     (w_emit_ready),
        .o_strobe    (o_strobe),
        .o_char_code (o_char_code),
        .o_text_x    (o_text_x),
        .o_text_y    (o_text_y),
        .o_last_char (o_last_char)
    );

endmodule
